// ----- rtl/kss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_pkg
// Types and constants shared by the nearly sorted stream sorter.
// ----------------------------------------------------------------------------
package kss_pkg;

  localparam int WS_W = 5;
  localparam logic [WS_W-1:0] WS_RESET = 5'd4;

  typedef logic signed [31:0] data_t;

  typedef struct packed {
    data_t value;
    logic  last_item;
  } in_word_t;

  typedef struct packed {
    data_t sorted_value;
    logic  end_of_sequence;
  } out_word_t;

  typedef struct packed {
    logic [WS_W-1:0] window_size;
  } cfg_word_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic insert;
    logic pop;
    logic eos;
  } dp_cmd_t;

  typedef struct packed {
    logic above_k;
    logic empty;
    logic one_left;
  } dp_sts_t;

endpackage

// ----- rtl/kss_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_chan_if
// Valid/ready channel carrying one word of a chosen payload type.
// ----------------------------------------------------------------------------
interface kss_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/kss_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_datapath
// Sorted window of registers with compare-and-shift insertion, head removal,
// the window size register and the output word register.
// ----------------------------------------------------------------------------
module kss_datapath #(
  parameter int WINDOW_MAX = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kss_pkg::dp_cmd_t              cmd,
  input  kss_pkg::data_t                key,
  input  logic                          cfg_we,
  input  logic [kss_pkg::WS_W-1:0]      cfg_ws,
  output kss_pkg::dp_sts_t              sts,
  output kss_pkg::out_word_t            out_word
);
  import kss_pkg::*;

  localparam int CW   = $clog2(WINDOW_MAX + 2);
  localparam int CMPW = (CW > WS_W) ? CW : WS_W;
  localparam int NE   = WINDOW_MAX + 1;

  data_t           entries_r   [NE];
  data_t           entries_nxt [NE];
  logic [CW-1:0]   count_r, count_nxt;
  logic [WS_W-1:0] window_size_r;
  out_word_t       out_r;
  logic [NE-1:0]   gt;
  logic [CMPW-1:0] k_eff, ws_ext, max_ext, cnt_ext;

  always_comb begin
    ws_ext  = CMPW'(window_size_r);
    max_ext = CMPW'(WINDOW_MAX);
    k_eff   = (ws_ext > max_ext) ? max_ext : ws_ext;
    cnt_ext = CMPW'(count_r);
    sts.above_k  = cnt_ext > k_eff;
    sts.empty    = count_r == '0;
    sts.one_left = count_r == CW'(1);
  end

  always_comb begin
    for (int i = 0; i < NE; i++) begin
      gt[i] = (CW'(i) < count_r) && (entries_r[i] > key);
    end
  end

  always_comb begin
    count_nxt = count_r;
    for (int i = 0; i < NE; i++) begin
      entries_nxt[i] = entries_r[i];
    end
    if (cmd.insert) begin
      count_nxt = count_r + CW'(1);
      if (gt[0] || count_r == '0) begin
        entries_nxt[0] = key;
      end
      for (int i = 1; i < NE; i++) begin
        if (gt[i-1]) begin
          entries_nxt[i] = entries_r[i-1];
        end else if (gt[i] || CW'(i) == count_r) begin
          entries_nxt[i] = key;
        end
      end
    end else if (cmd.pop) begin
      count_nxt = count_r - CW'(1);
      for (int i = 0; i < NE - 1; i++) begin
        entries_nxt[i] = entries_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NE; i++) begin
      entries_r[i] <= entries_nxt[i];
    end
    if (cmd.pop) begin
      out_r.sorted_value    <= entries_r[0];
      out_r.end_of_sequence <= cmd.eos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r       <= '0;
      window_size_r <= WS_RESET;
    end else begin
      count_r <= count_nxt;
      if (cfg_we) begin
        window_size_r <= cfg_ws;
      end
    end
  end

  assign out_word = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(WINDOW_MAX + 1))
    else $error("window count beyond capacity");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.insert && cmd.pop))
    else $error("insert and pop in the same cycle");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> count_r != '0)
    else $error("pop from an empty window");

endmodule

// ----- rtl/kss_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_controller
// State machine that accepts words, drives insertion and drains the window
// into the output register.
// ----------------------------------------------------------------------------
module kss_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  kss_pkg::dp_sts_t  sts,
  output kss_pkg::dp_cmd_t  cmd
);
  import kss_pkg::*;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   need_pop, slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    in_ready      = 1'b0;
    cmd           = '0;
    slot_free     = !out_valid_r || out_ready;
    need_pop      = last_r ? !sts.empty : sts.above_k;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        if (in_valid && in_ready) begin
          cmd.insert = 1'b1;
          last_nxt   = in_last;
          state_nxt  = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (need_pop) begin
          if (slot_free) begin
            cmd.pop       = 1'b1;
            cmd.eos       = last_r && sts.one_left;
            out_valid_nxt = 1'b1;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_pop_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (!out_valid_r || out_ready))
    else $error("output word overwritten before it was taken");

  a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN && state_nxt == ST_IDLE && last_r) |-> sts.empty)
    else $error("flush finished with values left in the window");

  a_accept_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == ST_DRAIN)
    else $error("accepted word not followed by a drain check");

endmodule

// ----- rtl/k_sorted_stream_sorter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_sorted_stream_sorter
// Sorts a stream in which each value lies at most k places from its sorted
// position, using a sorted window of up to k + 1 registers.
// ----------------------------------------------------------------------------
//  Channel    Direction  Word
//  in_chan    sink       value, last_item
//  out_chan   source     sorted_value, end_of_sequence
//  cfg_chan   sink       window_size (ready whenever out of reset)
//
// A word is inserted in the cycle it is accepted by the compare-and-shift
// window; the controller then pops results from the window head into the
// output register and checks the window count before it returns to accepting.
// A stalled output holds the drain, while a new word may still be taken as
// a result waits in the output register.
// Reset clears the window count and sets the window size to four; the
// window registers themselves need no clearing.
// ----------------------------------------------------------------------------
module k_sorted_stream_sorter #(
  parameter int WINDOW_MAX = 16
) (
  input logic       clk,
  input logic       rst_n,
  kss_chan_if.sink   in_chan,
  kss_chan_if.source out_chan,
  kss_chan_if.sink   cfg_chan
);
  import kss_pkg::*;

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  out_word_t out_word;
  in_word_t  in_word;
  cfg_word_t cfg_word;

  assign in_word  = in_chan.payload;
  assign cfg_word = cfg_chan.payload;
  assign cfg_chan.ready   = rst_n;
  assign out_chan.payload = out_word;

  kss_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_last   (in_word.last_item),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  kss_datapath #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .key      (in_word.value),
    .cfg_we   (cfg_chan.valid),
    .cfg_ws   (cfg_word.window_size),
    .sts      (sts),
    .out_word (out_word)
  );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nearly sorted stream sorter. A directed table
// covers reset state, extreme values, equal values, a zero window, a window
// size above the maximum and a window shrunk while it holds values. Random
// sequences follow, mostly nearly sorted with some noise and unterminated
// runs, under several window sizes and idle patterns. Every output word is
// compared with a local model of the sorted window or with a typed table result.
// ----------------------------------------------------------------------------
module tb_top;
  import kss_pkg::*;

  localparam int WINDOW_MAX = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_PHASES = 9;
  localparam int ITEMS_PER_PHASE = 40;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    data_t     value;
    logic      last;
    logic      typed;
    data_t     exp_value;
    logic      exp_eos;
  } stim_row_t;

  localparam int N_ROWS = 28;
  localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
    '{ROW_ITEM, -32'sd5, 1'b1, 1'b1, -32'sd5, 1'b1},
    '{ROW_ITEM, 32'sd3, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 32'h8000_0000, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 32'sd3, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 32'sd0, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, -32'sd1, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 32'sd1, 1'b1, 1'b0, 32'sd0, 1'b0},
    '{ROW_CFG, 32'sd0, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b0},
    '{ROW_ITEM, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000, 1'b0},
    '{ROW_ITEM, 32'sd0, 1'b1, 1'b1, 32'sd0, 1'b1},
    '{ROW_CFG, 32'sd31, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 32'sd10, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, -32'sd10, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 32'sd20, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, -32'sd20, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 32'sd5, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 32'sd5, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_CFG, 32'sd2, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 32'sd0, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 32'sd1, 1'b1, 1'b0, 32'sd0, 1'b0},
    '{ROW_CFG, 32'sd3, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 32'sd9, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 32'sd8, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_CFG, 32'sd0, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 32'sd1, 1'b0, 1'b0, 32'sd0, 1'b0},
    '{ROW_ITEM, 32'sd4, 1'b1, 1'b1, 32'sd4, 1'b1}
  };

  logic clk;
  logic rst_n;

  kss_chan_if #(.payload_t(in_word_t))  in_if ();
  kss_chan_if #(.payload_t(out_word_t)) out_if ();
  kss_chan_if #(.payload_t(cfg_word_t)) cfg_if ();

  k_sorted_stream_sorter #(
    .WINDOW_MAX(WINDOW_MAX)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if),
    .cfg_chan(cfg_if)
  );

  data_t           sort_window_q[$];
  logic [WS_W-1:0] window_size_model = WS_RESET;
  out_word_t       sorted_expect_q[$];
  int              mismatch_count = 0;
  int              cycle_count = 0;
  int              send_idle_pct = 10;
  int              recv_idle_pct = 47;

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.payload = '0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void sort_window_step(input data_t v, input logic last,
                                           ref out_word_t emitted[$]);
    int unsigned pos;
    int unsigned eff_k;
    eff_k = (window_size_model > WINDOW_MAX) ? WINDOW_MAX : window_size_model;
    pos = sort_window_q.size();
    while (pos > 0 && sort_window_q[pos-1] > v) pos--;
    sort_window_q.insert(pos, v);
    if (last) begin
      while (sort_window_q.size() > 0) begin
        emitted.insert(emitted.size(), {sort_window_q[0], sort_window_q.size() == 1});
        void'(sort_window_q.pop_front());
      end
    end else begin
      while (sort_window_q.size() > eff_k) begin
        emitted.insert(emitted.size(), {sort_window_q.pop_front(), 1'b0});
      end
    end
  endfunction

  task automatic send_word(input data_t v, input logic last, input logic typed,
                           input out_word_t typed_word);
    out_word_t fresh[$];
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= {v, last};
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sort_window_step(v, last, fresh);
    if (typed) begin
      sorted_expect_q.insert(sorted_expect_q.size(), typed_word);
    end else begin
      foreach (fresh[j]) sorted_expect_q.insert(sorted_expect_q.size(), fresh[j]);
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (sorted_expect_q.size() != 0);
  endtask

  task automatic write_window_size(input logic [WS_W-1:0] ws);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.payload <= ws;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    window_size_model = ws;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (sorted_expect_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word, expected none, actual value %0d eos %0b",
                 $time, out_if.payload.sorted_value, out_if.payload.end_of_sequence);
      end else begin
        want = sorted_expect_q.pop_front();
        if (out_if.payload.sorted_value !== want.sorted_value) begin
          mismatch_count++;
          $display("%0t: sorted_value expected %0d actual %0d", $time,
                   want.sorted_value, out_if.payload.sorted_value);
        end
        if (out_if.payload.end_of_sequence !== want.end_of_sequence) begin
          mismatch_count++;
          $display("%0t: end_of_sequence expected %0b actual %0b", $time,
                   want.end_of_sequence, out_if.payload.end_of_sequence);
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t       row;
    logic [WS_W-1:0] phase_ws [RANDOM_PHASES];
    data_t           base;
    data_t           v;
    logic            last;
    int              seq_len;
    int              sent;
    int              roll;
    bit              held_off;

    phase_ws = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd7, 5'd2, 5'd0, 5'd4, 5'd15};
    phase_ws[6] = $urandom_range(31);
    held_off = 1'b0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_ROWS; r++) begin
      row = DIRECTED_ROWS[r];
      if (row.kind == ROW_CFG) begin
        write_window_size(row.value[WS_W-1:0]);
      end else begin
        send_word(row.value, row.last, row.typed, {row.exp_value, row.exp_eos});
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_window_size(phase_ws[ph]);
      send_idle_pct = (ph < 3) ? 10 : (ph < 6) ? 47 : 0;
      recv_idle_pct = (ph < 3) ? 47 : (ph < 6) ? 10 : 0;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if (sent >= ITEMS_PER_PHASE / 2 && !held_off) begin
          wait_drained();
          held_off = 1'b1;
        end
        seq_len = $urandom_range(1, 24);
        base = data_t'($urandom);
        for (int i = 0; i < seq_len && sent < ITEMS_PER_PHASE; i++) begin
          roll = $urandom_range(99);
          if (roll < 15) begin
            v = data_t'($urandom);
          end else if (roll < 20) begin
            v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
          end else begin
            v = base + data_t'($urandom_range(16)) - 32'sd8;
            base = base + data_t'($urandom_range(6));
          end
          if (i == seq_len - 1) last = ($urandom_range(9) != 0);
          else last = ($urandom_range(49) == 0);
          send_word(v, last, 1'b0, '0);
          sent++;
        end
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
